// ===== hdl/ftgc_pkg.sv =====
// Types, codes and byte-update functions shared by the frame trailer generator and checker.
package ftgc_pkg;

    localparam logic [1:0] METHOD_EVEN = 2'd0;
    localparam logic [1:0] METHOD_ODD  = 2'd1;
    localparam logic [1:0] METHOD_CSUM = 2'd2;
    localparam logic [1:0] METHOD_CRC  = 2'd3;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_TRAILER = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] CFG_METHOD     = 2'd0;
    localparam logic [1:0] CFG_CHECK_MODE = 2'd1;
    localparam logic [1:0] CFG_CRC_POLY   = 2'd2;
    localparam logic [1:0] CFG_CRC_INIT   = 2'd3;

    localparam logic [1:0]  METHOD_RESET   = METHOD_CRC;
    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
    localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       run_end;
        logic       ok;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] sum16_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== hdl/frame_trailer_generate_check_top.sv =====
// Frame trailer generator and checker: parity, 16-bit checksum or CRC-16 over a byte stream.
//
// One byte is taken per clock cycle while the queue has room. Each request passes an input
// register and a single stage of byte-wide update logic (one CRC byte step, one end-around
// add) into a four-entry result queue that drains one result per cycle while m_ready is high;
// the input is taken whenever the queue, after this cycle's drain, holds at most one result.
// A frame end in generate mode queues up to three results, so the input pauses while they
// drain. In check mode, a change to a parity method while two bytes are held makes that byte
// wait while the oldest held byte is released first.
module frame_trailer_generate_check_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_kind,
    output logic        m_run_end,
    output logic        m_ok
);

    localparam int QDEPTH = 4;

    logic [1:0]  method_reg;
    logic        check_mode_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_init_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_end_reg;

    logic [15:0] crc_reg, crc_next;
    logic [15:0] sum_reg, sum_next;
    logic        par_reg, par_next;
    logic        pend_reg, pend_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  d0_reg, d0_next;
    logic [7:0]  d1_reg, d1_next;
    logic [1:0]  fill_reg, fill_next;

    ftgc_pkg::result_t q_reg [QDEPTH];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  rd_ptr_reg;
    logic [2:0]  count_reg;

    ftgc_pkg::result_t res [3];
    logic [1:0]  n_res;
    logic        consume_item;
    logic        frame_done;

    logic        tlen1;
    logic        drain;
    logic        ab_en;
    logic [7:0]  ab_byte;
    logic        par_a;
    logic        pend_a;
    logic [7:0]  hold_a;
    logic [15:0] sum_a;
    logic [15:0] crc_a;
    logic        parity_bit;
    logic [15:0] trailer_word;
    logic [15:0] recv_word;
    logic        match;
    ftgc_pkg::result_t status_res;
    ftgc_pkg::result_t payload_res;

    logic        pop;
    logic [2:0]  count_after_pop;
    logic        room;
    logic        step_go;

    assign pop             = (count_reg != 3'd0) && m_ready;
    assign count_after_pop = count_reg - {2'b00, pop};
    assign room            = count_after_pop <= 3'd1;
    assign step_go         = in_valid_reg && room;
    assign s_ready         = !in_valid_reg || (step_go && consume_item);

    assign m_valid    = count_reg != 3'd0;
    assign m_out_byte = q_reg[rd_ptr_reg].out_byte;
    assign m_kind     = q_reg[rd_ptr_reg].kind;
    assign m_run_end  = q_reg[rd_ptr_reg].run_end;
    assign m_ok       = q_reg[rd_ptr_reg].ok;

    always_comb begin
        tlen1 = (method_reg == ftgc_pkg::METHOD_EVEN) || (method_reg == ftgc_pkg::METHOD_ODD);
        drain = check_mode_reg && (fill_reg == 2'd2) && tlen1;

        // In check mode the oldest held byte is the one released to the accumulators.
        ab_byte = check_mode_reg ? d0_reg : in_byte_reg;
        ab_en   = !check_mode_reg || (tlen1 ? (fill_reg != 2'd0) : (fill_reg == 2'd2));

        par_a  = par_reg ^ (ab_en & (^ab_byte));
        pend_a = pend_reg;
        hold_a = hold_reg;
        sum_a  = sum_reg;
        if (ab_en) begin
            if (pend_reg) begin
                sum_a  = ftgc_pkg::sum16_add(sum_reg, {hold_reg, ab_byte});
                pend_a = 1'b0;
            end else begin
                hold_a = ab_byte;
                pend_a = 1'b1;
            end
        end
        crc_a = ab_en ? ftgc_pkg::crc16_byte(crc_reg, ab_byte, crc_poly_reg) : crc_reg;

        parity_bit = (method_reg == ftgc_pkg::METHOD_EVEN) ? par_a : ~par_a;
        if (method_reg == ftgc_pkg::METHOD_CSUM) begin
            trailer_word = ~(pend_a ? ftgc_pkg::sum16_add(sum_a, {hold_a, 8'h00}) : sum_a);
        end else begin
            trailer_word = crc_a;
        end

        recv_word = {(fill_reg == 2'd2) ? d1_reg : d0_reg, in_byte_reg};
        match     = tlen1 ? (in_byte_reg[0] == parity_bit) : (recv_word == trailer_word);

        status_res  = '{out_byte: 8'h00, kind: ftgc_pkg::KIND_STATUS, run_end: 1'b1, ok: match};
        payload_res = '{out_byte: ab_byte, kind: ftgc_pkg::KIND_PAYLOAD, run_end: 1'b0,
                        ok: 1'b0};

        crc_next     = crc_a;
        sum_next     = sum_a;
        par_next     = par_a;
        pend_next    = pend_a;
        hold_next    = hold_a;
        d0_next      = d0_reg;
        d1_next      = d1_reg;
        fill_next    = fill_reg;
        consume_item = 1'b1;
        frame_done   = 1'b0;
        n_res        = 2'd0;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end

        if (!check_mode_reg) begin
            res[0]    = payload_res;
            n_res     = 2'd1;
            fill_next = 2'd0;
            if (in_end_reg) begin
                frame_done = 1'b1;
                if (tlen1) begin
                    res[1] = '{out_byte: {7'd0, parity_bit}, kind: ftgc_pkg::KIND_TRAILER,
                               run_end: 1'b1, ok: 1'b0};
                    n_res  = 2'd2;
                end else begin
                    res[1] = '{out_byte: trailer_word[15:8], kind: ftgc_pkg::KIND_TRAILER,
                               run_end: 1'b0, ok: 1'b0};
                    res[2] = '{out_byte: trailer_word[7:0], kind: ftgc_pkg::KIND_TRAILER,
                               run_end: 1'b1, ok: 1'b0};
                    n_res  = 2'd3;
                end
            end
        end else if (drain) begin
            // Two bytes held but only one needed: release the oldest and retry this byte.
            res[0]       = payload_res;
            n_res        = 2'd1;
            d0_next      = d1_reg;
            d1_next      = 8'h00;
            fill_next    = 2'd1;
            consume_item = 1'b0;
        end else if (in_end_reg && !tlen1 && (fill_reg == 2'd0)) begin
            res[0]     = '{out_byte: 8'h00, kind: ftgc_pkg::KIND_STATUS, run_end: 1'b1,
                           ok: 1'b0};
            n_res      = 2'd1;
            frame_done = 1'b1;
        end else begin
            if (in_end_reg) begin
                frame_done = 1'b1;
                if (ab_en) begin
                    res[0] = payload_res;
                    res[1] = status_res;
                    n_res  = 2'd2;
                end else begin
                    res[0] = status_res;
                    n_res  = 2'd1;
                end
            end else begin
                if (ab_en) begin
                    res[0] = payload_res;
                    n_res  = 2'd1;
                end
                if (tlen1 || (fill_reg == 2'd0)) begin
                    d0_next   = in_byte_reg;
                    d1_next   = 8'h00;
                    fill_next = 2'd1;
                end else begin
                    d0_next   = (fill_reg == 2'd2) ? d1_reg : d0_reg;
                    d1_next   = in_byte_reg;
                    fill_next = 2'd2;
                end
            end
        end

        if (frame_done) begin
            crc_next  = crc_init_reg;
            sum_next  = 16'h0000;
            par_next  = 1'b0;
            pend_next = 1'b0;
            hold_next = 8'h00;
            d0_next   = 8'h00;
            d1_next   = 8'h00;
            fill_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg     <= ftgc_pkg::METHOD_RESET;
            check_mode_reg <= 1'b0;
            crc_poly_reg   <= ftgc_pkg::CRC_POLY_RESET;
            crc_init_reg   <= ftgc_pkg::CRC_INIT_RESET;
            in_valid_reg   <= 1'b0;
            crc_reg        <= ftgc_pkg::CRC_INIT_RESET;
            sum_reg        <= 16'h0000;
            par_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            hold_reg       <= 8'h00;
            d0_reg         <= 8'h00;
            d1_reg         <= 8'h00;
            fill_reg       <= 2'd0;
            wr_ptr_reg     <= 2'd0;
            rd_ptr_reg     <= 2'd0;
            count_reg      <= 3'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step_go && consume_item) begin
                in_valid_reg <= 1'b0;
            end

            if (cfg_wr_en && (cfg_index == ftgc_pkg::CFG_CRC_INIT)) begin
                crc_reg <= cfg_data;
            end else if (step_go) begin
                crc_reg <= crc_next;
            end

            if (step_go) begin
                sum_reg    <= sum_next;
                par_reg    <= par_next;
                pend_reg   <= pend_next;
                hold_reg   <= hold_next;
                d0_reg     <= d0_next;
                d1_reg     <= d1_next;
                fill_reg   <= fill_next;
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end

            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_after_pop + (step_go ? {1'b0, n_res} : 3'd0);

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ftgc_pkg::CFG_METHOD:     method_reg     <= cfg_data[1:0];
                    ftgc_pkg::CFG_CHECK_MODE: check_mode_reg <= cfg_data[0];
                    ftgc_pkg::CFG_CRC_POLY:   crc_poly_reg   <= cfg_data;
                    ftgc_pkg::CFG_CRC_INIT:   crc_init_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_frame_end;
        end
        if (step_go) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_res) begin
                    q_reg[wr_ptr_reg + 2'(i)] <= res[i];
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(QDEPTH))
        else $error("result queue holds more entries than it has");

    a_hold_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("more than two bytes held back as trailer");

    a_frame_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && consume_item && in_end_reg |=> (fill_reg == 2'd0) && !pend_reg)
        else $error("frame state not cleared after the last byte");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the frame trailer generator and checker, driven by directed and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQUEST_TARGET = 450;
    localparam int WAIT_MAX       = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 400;

    class frame_check_board;
        logic [1:0]  method;
        logic        check_mode;
        logic [15:0] crc_poly;
        logic [15:0] crc_init;
        logic [15:0] crc;
        logic [15:0] csum;
        logic        parity;
        logic        half_word;
        logic [7:0]  high_byte;
        logic [7:0]  held [2];
        int          held_count;
        ftgc_pkg::result_t pending_results[$];
        int          errors;
        int          requests;
        int          results;
        int          statuses;
        int          matched;

        function new();
            method     = ftgc_pkg::METHOD_RESET;
            check_mode = 1'b0;
            crc_poly   = ftgc_pkg::CRC_POLY_RESET;
            crc_init   = ftgc_pkg::CRC_INIT_RESET;
            errors     = 0;
            requests   = 0;
            results    = 0;
            statuses   = 0;
            matched    = 0;
            restart();
        endfunction

        function void restart();
            crc        = crc_init;
            csum       = 16'h0000;
            parity     = 1'b0;
            half_word  = 1'b0;
            high_byte  = 8'h00;
            held[0]    = 8'h00;
            held[1]    = 8'h00;
            held_count = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [15:0] value);
            unique case (index)
                ftgc_pkg::CFG_METHOD: method = value[1:0];
                ftgc_pkg::CFG_CHECK_MODE: check_mode = value[0];
                ftgc_pkg::CFG_CRC_POLY: crc_poly = value;
                ftgc_pkg::CFG_CRC_INIT: begin
                    crc_init = value;
                    crc      = value;
                end
                default: ;
            endcase
        endfunction

        function logic [15:0] ones_add(logic [15:0] acc, logic [15:0] word);
            logic [16:0] total;
            total = {1'b0, acc} + {1'b0, word};
            if (total[16]) begin
                total = {1'b0, total[15:0]} + 17'd1;
            end
            return total[15:0];
        endfunction

        function logic [15:0] crc_step(logic [15:0] start, logic [7:0] data);
            logic [15:0] r;
            logic        top;
            r = start ^ {data, 8'h00};
            for (int i = 0; i < 8; i++) begin
                top = r[15];
                r   = r << 1;
                if (top) begin
                    r = r ^ crc_poly;
                end
            end
            return r;
        endfunction

        function void absorb(logic [7:0] data);
            parity = parity ^ (^data);
            if (half_word) begin
                csum      = ones_add(csum, {high_byte, data});
                half_word = 1'b0;
            end else begin
                high_byte = data;
                half_word = 1'b1;
            end
            crc = crc_step(crc, data);
        endfunction

        function logic [15:0] trailer_word();
            if (method == ftgc_pkg::METHOD_CSUM) begin
                if (half_word) begin
                    csum      = ones_add(csum, {high_byte, 8'h00});
                    half_word = 1'b0;
                end
                return ~csum;
            end
            return crc;
        endfunction

        function logic parity_bit();
            return (method == ftgc_pkg::METHOD_EVEN) ? parity : ~parity;
        endfunction

        function int trailer_len();
            return (method == ftgc_pkg::METHOD_EVEN || method == ftgc_pkg::METHOD_ODD) ? 1 : 2;
        endfunction

        function void expect_result(logic [7:0] data, logic [1:0] kind, logic run_end, logic ok);
            ftgc_pkg::result_t r;
            r.out_byte = data;
            r.kind     = kind;
            r.run_end  = run_end;
            r.ok       = ok;
            pending_results = {pending_results, r};
        endfunction

        function void take_byte(logic [7:0] data, logic last);
            logic [7:0]  cand [3];
            logic [15:0] word;
            logic        match;
            int          n;
            int          keep;
            int          tlen;
            requests++;
            tlen = trailer_len();
            if (!check_mode) begin
                held_count = 0;
                absorb(data);
                expect_result(data, ftgc_pkg::KIND_PAYLOAD, 1'b0, 1'b0);
                if (last) begin
                    if (tlen == 1) begin
                        expect_result({7'd0, parity_bit()}, ftgc_pkg::KIND_TRAILER, 1'b1, 1'b0);
                    end else begin
                        word = trailer_word();
                        expect_result(word[15:8], ftgc_pkg::KIND_TRAILER, 1'b0, 1'b0);
                        expect_result(word[7:0], ftgc_pkg::KIND_TRAILER, 1'b1, 1'b0);
                    end
                    restart();
                end
                return;
            end
            n = 0;
            for (int i = 0; i < held_count && i < 2; i++) begin
                cand[n] = held[i];
                n++;
            end
            cand[n] = data;
            n++;
            keep = (n > tlen) ? n - tlen : 0;
            if (last && n < tlen) begin
                expect_result(8'h00, ftgc_pkg::KIND_STATUS, 1'b1, 1'b0);
                restart();
                return;
            end
            for (int i = 0; i < keep; i++) begin
                absorb(cand[i]);
                expect_result(cand[i], ftgc_pkg::KIND_PAYLOAD, 1'b0, 1'b0);
            end
            if (last) begin
                if (tlen == 1) begin
                    match = (cand[n-1][0] == parity_bit());
                end else begin
                    match = ({cand[n-2], cand[n-1]} == trailer_word());
                end
                expect_result(8'h00, ftgc_pkg::KIND_STATUS, 1'b1, match);
                restart();
                return;
            end
            held_count = n - keep;
            for (int i = 0; i < 2; i++) begin
                held[i] = (i < held_count) ? cand[keep + i] : 8'h00;
            end
        endfunction

        // The trailer that a fresh frame with this payload needs under the present settings.
        function logic [15:0] trailer_for(logic [7:0] payload[$]);
            logic [15:0] saved_crc;
            logic [15:0] saved_csum;
            logic        saved_parity;
            logic        saved_half;
            logic [7:0]  saved_high;
            logic [15:0] value;
            saved_crc    = crc;
            saved_csum   = csum;
            saved_parity = parity;
            saved_half   = half_word;
            saved_high   = high_byte;
            crc          = crc_init;
            csum         = 16'h0000;
            parity       = 1'b0;
            half_word    = 1'b0;
            high_byte    = 8'h00;
            foreach (payload[i]) begin
                absorb(payload[i]);
            end
            value     = (trailer_len() == 1) ? {15'd0, parity_bit()} : trailer_word();
            crc       = saved_crc;
            csum      = saved_csum;
            parity    = saved_parity;
            half_word = saved_half;
            high_byte = saved_high;
            return value;
        endfunction

        task flag_mismatch(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task compare_result(ftgc_pkg::result_t got);
            ftgc_pkg::result_t want;
            results++;
            if (got.kind == ftgc_pkg::KIND_STATUS) begin
                statuses++;
                if (got.ok) begin
                    matched++;
                end
            end
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result %0d (byte %02h, kind %0d) with nothing expected",
                                        results, got.out_byte, got.kind));
                return;
            end
            want = pending_results.pop_front();
            if (got.out_byte !== want.out_byte) begin
                flag_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                        results, got.out_byte, want.out_byte));
            end
            if (got.kind !== want.kind) begin
                flag_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                        results, got.kind, want.kind));
            end
            if (got.run_end !== want.run_end) begin
                flag_mismatch($sformatf("result %0d run_end %0b, expected %0b",
                                        results, got.run_end, want.run_end));
            end
            if (got.ok !== want.ok) begin
                flag_mismatch($sformatf("result %0d ok %0b, expected %0b",
                                        results, got.ok, want.ok));
            end
        endtask
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = ftgc_pkg::CFG_METHOD;
    logic [15:0] cfg_data    = 16'h0000;
    logic        s_valid     = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_frame_end = 1'b0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_out_byte;
    logic [1:0]  m_kind;
    logic        m_run_end;
    logic        m_ok;

    logic        calm = 1'b0;
    int unsigned quiet_cycles = 0;
    frame_check_board board;

    frame_trailer_generate_check_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_kind      (m_kind),
        .m_run_end   (m_run_end),
        .m_ok        (m_ok)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        ftgc_pkg::result_t got;
        int      stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, WAIT_MAX);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            got.out_byte = m_out_byte;
            got.kind     = m_kind;
            got.run_end  = m_run_end;
            got.ok       = m_ok;
            board.compare_result(got);
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, WAIT_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_frame_end <= last;
        do @(posedge aclk); while (!(s_valid && s_ready));
        board.take_byte(data, last);
    endtask

    task automatic send_frame(input logic [7:0] frame_bytes[$]);
        foreach (frame_bytes[i]) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Appends the right trailer to the payload, then optionally flips one bit somewhere.
    task automatic send_checked_frame(input logic [7:0] payload[$], input logic corrupt);
        logic [7:0]  frame_bytes[$];
        logic [15:0] trailer;
        int          idx;
        trailer     = board.trailer_for(payload);
        frame_bytes = payload;
        if (board.trailer_len() == 1) begin
            frame_bytes = {frame_bytes, {7'($urandom), trailer[0]}};
        end else begin
            frame_bytes = {frame_bytes, trailer[15:8]};
            frame_bytes = {frame_bytes, trailer[7:0]};
        end
        if (corrupt) begin
            idx = $urandom_range(0, frame_bytes.size() - 1);
            frame_bytes[idx] = frame_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
        end
        send_frame(frame_bytes);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_register(input logic [1:0] index, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        board.write_register(index, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] frame_bytes[$];
        int         frames;
        int         length;
        int         choice;
        board = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        frame_bytes = '{8'h00, 8'hFF};
        send_frame(frame_bytes);
        settle();
        program_register(ftgc_pkg::CFG_METHOD, 16'(ftgc_pkg::METHOD_EVEN));
        frame_bytes = '{8'hA5};
        send_frame(frame_bytes);
        settle();
        program_register(ftgc_pkg::CFG_METHOD, 16'(ftgc_pkg::METHOD_ODD));
        frame_bytes = '{8'h80};
        send_frame(frame_bytes);
        settle();
        program_register(ftgc_pkg::CFG_METHOD, 16'(ftgc_pkg::METHOD_CSUM));
        frame_bytes = '{8'hFF, 8'hFF, 8'h01};
        send_frame(frame_bytes);
        settle();
        program_register(ftgc_pkg::CFG_CHECK_MODE, 16'd1);
        frame_bytes = '{8'h12, 8'h34, 8'h56};
        send_checked_frame(frame_bytes, 1'b0);
        settle();
        program_register(ftgc_pkg::CFG_METHOD, 16'(ftgc_pkg::METHOD_CRC));
        program_register(ftgc_pkg::CFG_CRC_POLY, 16'hFFFF);
        program_register(ftgc_pkg::CFG_CRC_INIT, 16'h0000);
        frame_bytes = '{8'h7E};
        send_checked_frame(frame_bytes, 1'b0);
        frame_bytes = '{8'h55};
        send_frame(frame_bytes);
        settle();
        program_register(ftgc_pkg::CFG_METHOD, 16'(ftgc_pkg::METHOD_EVEN));
        frame_bytes = '{8'h03, 8'hFE};
        send_frame(frame_bytes);
        settle();

        // Two bytes held for a CRC trailer are released when parity takes over mid-frame.
        program_register(ftgc_pkg::CFG_METHOD, 16'(ftgc_pkg::METHOD_CRC));
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        settle();
        program_register(ftgc_pkg::CFG_METHOD, 16'(ftgc_pkg::METHOD_ODD));
        send_byte(8'h81, 1'b1);
        settle();

        // A byte held in check mode is dropped when the next one arrives in generate mode.
        send_byte(8'hAA, 1'b0);
        settle();
        program_register(ftgc_pkg::CFG_CHECK_MODE, 16'd0);
        send_byte(8'h55, 1'b1);
        settle();

        // Loading a new initial value mid-frame restarts that frame's CRC.
        program_register(ftgc_pkg::CFG_METHOD, 16'(ftgc_pkg::METHOD_CRC));
        program_register(ftgc_pkg::CFG_CRC_POLY, 16'h1021);
        send_byte(8'h01, 1'b0);
        settle();
        program_register(ftgc_pkg::CFG_CRC_INIT, 16'h1D0F);
        send_byte(8'hFE, 1'b1);

        while (board.requests < REQUEST_TARGET) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            program_register(ftgc_pkg::CFG_METHOD, 16'($urandom_range(0, 3)));
            program_register(ftgc_pkg::CFG_CHECK_MODE, 16'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0) begin
                program_register(ftgc_pkg::CFG_CRC_POLY, pick_word());
            end
            if ($urandom_range(0, 2) == 0) begin
                program_register(ftgc_pkg::CFG_CRC_INIT, pick_word());
            end
            frames = $urandom_range(1, 5);
            repeat (frames) begin
                choice = $urandom_range(0, 19);
                length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(0, 8);
                frame_bytes.delete();
                repeat (length) frame_bytes = {frame_bytes, 8'($urandom)};
                if (!board.check_mode) begin
                    if (frame_bytes.size() == 0) begin
                        frame_bytes = {frame_bytes, 8'($urandom)};
                    end
                    send_frame(frame_bytes);
                end else if (choice < 14) begin
                    send_checked_frame(frame_bytes, 1'b0);
                end else if (choice < 17) begin
                    send_checked_frame(frame_bytes, 1'b1);
                end else begin
                    frame_bytes.delete();
                    repeat ($urandom_range(1, 3)) frame_bytes = {frame_bytes, 8'($urandom)};
                    send_frame(frame_bytes);
                end
            end
            // Leave a frame open so that the next settings are written mid-frame.
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end
        end
        settle();

        $display("run covered %0d input bytes and %0d results, %0d frame checks (%0d matched)",
                 board.requests, board.results, board.statuses, board.matched);
        $display("%0d mismatches over all methods, both modes and mid-frame changes",
                 board.errors);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ftgc_pkg.sv
hdl/frame_trailer_generate_check_top.sv
verif/testbench.sv
